// ===== hw/rtl/audio_modulated_circle_points_top_defines.svh =====
// Assertion macros for the audio circle point generator checker.
// Needs clk and arst_n in scope where a macro is used.
`ifndef AUDIO_MODULATED_CIRCLE_POINTS_TOP_DEFINES_SVH
`define AUDIO_MODULATED_CIRCLE_POINTS_TOP_DEFINES_SVH

// same-cycle implication
`define AMCP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define AMCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== hw/rtl/amcp_pkg.sv =====
// Shared types and constants of the audio circle point generator.
// No dependencies.
package amcp_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int BASE_W     = 10;
	localparam int GAIN_W     = 4;
	localparam int CENTER_W   = 12;
	localparam int COORD_W    = 12;
	localparam int LEVEL_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int RAD_W      = 14;
	localparam int RAD_MAG_W  = 12;
	localparam int DIGIT_W    = 4;
	localparam int DIGITS     = 3;
	localparam int DCNT_W     = 2;

	localparam int SAMPLE_MID = 128;
	localparam int COORD_MAX  = 4095;

	localparam logic [BASE_W-1:0]   BASE_RESET   = 10'd200;
	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 4'd5;
	localparam logic [CENTER_W-1:0] CENTER_RESET = 12'd2048;

	localparam logic [LEVEL_W-1:0] LEVEL_ON  = 8'hFF;
	localparam logic [LEVEL_W-1:0] LEVEL_OFF = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_RADIUS   = 2'd0,
		REG_AUDIO_GAIN    = 2'd1,
		REG_CENTER_OFFSET = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] audio_sample;
	} sample_t;

	typedef struct packed {
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
	} point_t;

endpackage

// ===== hw/rtl/amcp_stream_if.sv =====
// Valid/ready stream channel carrying one payload of type T.
// Used with amcp_pkg payload structs.
interface amcp_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/amcp_trig_rom.sv =====
// Cosine and sine table in signed Q1.F, built at elaboration from a
// Q2.30 Taylor series with quadrant folding. Registered read.
module amcp_trig_rom #(
	parameter int ANGLE_STEPS    = 360,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                               clk,
	input  logic [$clog2(ANGLE_STEPS)-1:0]     addr,
	output logic signed [TRIG_FRAC_BITS+1:0]   cos_s1,
	output logic signed [TRIG_FRAC_BITS+1:0]   sin_s1
);
	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1 << 30;
	localparam longint unsigned RND_Q30     = 64'd1 << (29 - TRIG_FRAC_BITS);

	logic signed [TW-1:0] cos_rom [ANGLE_STEPS];
	logic signed [TW-1:0] sin_rom [ANGLE_STEPS];

	for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_entry
		localparam longint unsigned FOUR = 64'(4 * k);
		localparam longint unsigned QUAD = (FOUR / ANGLE_STEPS) % 4;
		localparam longint unsigned REMN = FOUR % ANGLE_STEPS;
		localparam longint unsigned ANG  = (HALF_PI_Q30 * REMN) / ANGLE_STEPS;
		localparam longint unsigned ANG2 = (ANG * ANG) >> 30;

		localparam longint unsigned CT0 = ONE_Q30;
		localparam longint unsigned CT1 = ((CT0 * ANG2) >> 30) / 2;
		localparam longint unsigned CT2 = ((CT1 * ANG2) >> 30) / 12;
		localparam longint unsigned CT3 = ((CT2 * ANG2) >> 30) / 30;
		localparam longint unsigned CT4 = ((CT3 * ANG2) >> 30) / 56;
		localparam longint unsigned CT5 = ((CT4 * ANG2) >> 30) / 90;
		localparam longint unsigned CT6 = ((CT5 * ANG2) >> 30) / 132;
		localparam longint unsigned CT7 = ((CT6 * ANG2) >> 30) / 182;
		localparam longint unsigned CT8 = ((CT7 * ANG2) >> 30) / 240;
		localparam longint unsigned CT9 = ((CT8 * ANG2) >> 30) / 306;

		localparam longint unsigned ST0 = ANG;
		localparam longint unsigned ST1 = ((ST0 * ANG2) >> 30) / 6;
		localparam longint unsigned ST2 = ((ST1 * ANG2) >> 30) / 20;
		localparam longint unsigned ST3 = ((ST2 * ANG2) >> 30) / 42;
		localparam longint unsigned ST4 = ((ST3 * ANG2) >> 30) / 72;
		localparam longint unsigned ST5 = ((ST4 * ANG2) >> 30) / 110;
		localparam longint unsigned ST6 = ((ST5 * ANG2) >> 30) / 156;
		localparam longint unsigned ST7 = ((ST6 * ANG2) >> 30) / 210;
		localparam longint unsigned ST8 = ((ST7 * ANG2) >> 30) / 272;
		localparam longint unsigned ST9 = ((ST8 * ANG2) >> 30) / 342;

		localparam longint CSUM = longint'(CT0) - longint'(CT1) + longint'(CT2)
			- longint'(CT3) + longint'(CT4) - longint'(CT5) + longint'(CT6)
			- longint'(CT7) + longint'(CT8) - longint'(CT9);
		localparam longint SSUM = longint'(ST0) - longint'(ST1) + longint'(ST2)
			- longint'(ST3) + longint'(ST4) - longint'(ST5) + longint'(ST6)
			- longint'(ST7) + longint'(ST8) - longint'(ST9);

		localparam longint unsigned CMAG = (CSUM < 0) ? 64'd0 : 64'(CSUM);
		localparam longint unsigned SMAG = (SSUM < 0) ? 64'd0 : 64'(SSUM);
		localparam longint unsigned CRND = (CMAG + RND_Q30) >> (30 - TRIG_FRAC_BITS);
		localparam longint unsigned SRND = (SMAG + RND_Q30) >> (30 - TRIG_FRAC_BITS);

		localparam bit SIN_USES_COS = (QUAD == 1) || (QUAD == 3);
		localparam bit SIN_NEG      = (QUAD >= 2);
		localparam bit COS_USES_COS = (QUAD == 0) || (QUAD == 2);
		localparam bit COS_NEG      = (QUAD == 1) || (QUAD == 2);

		localparam longint unsigned SIN_MAG = SIN_USES_COS ? CRND : SRND;
		localparam longint unsigned COS_MAG = COS_USES_COS ? CRND : SRND;

		localparam longint SIN_L = SIN_NEG ? -longint'(SIN_MAG) : longint'(SIN_MAG);
		localparam longint COS_L = COS_NEG ? -longint'(COS_MAG) : longint'(COS_MAG);

		assign sin_rom[k] = TW'(SIN_L);
		assign cos_rom[k] = TW'(COS_L);
	end

	always_ff @(posedge clk) begin
		cos_s1 <= cos_rom[addr];
		sin_s1 <= sin_rom[addr];
	end

endmodule

// ===== hw/rtl/audio_modulated_circle_points_top.sv =====
// Audio circle point generator: one laser point per audio request.
// The point is registered in the finish state, after the multiply steps. A new request
// is taken only when idle or in the finish state with a free output, once the three
// 4-bit radius digits of the shift-add multiply and the add-and-saturate step are done.
// Reset (arst_n low, asynchronous): phase counter to zero, registers to their
// defaults, output empty. Depends on amcp_pkg, amcp_stream_if, amcp_trig_rom.
module audio_modulated_circle_points_top #(
	parameter int ANGLE_STEPS    = 360,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [amcp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [amcp_pkg::CFG_DATA_W-1:0]     cfg_data,
	amcp_stream_if.sink                         sample,
	amcp_stream_if.source                       point
);
	localparam int DW  = $clog2(ANGLE_STEPS);
	localparam int TW  = TRIG_FRAC_BITS + 2;
	localparam int AW  = TW + amcp_pkg::RAD_MAG_W;
	localparam int WW  = AW - TRIG_FRAC_BITS;
	localparam int MW  = TW + amcp_pkg::DIGIT_W + 1;
	localparam int XW  = DW + 2;

	amcp_pkg::state_t state_q, state_d;

	logic [amcp_pkg::BASE_W-1:0]   base_q;
	logic [amcp_pkg::GAIN_W-1:0]   gain_q;
	logic [amcp_pkg::CENTER_W-1:0] center_q;

	logic [DW-1:0] degree_q;
	logic [DW-1:0] deg_next;
	logic [DW-1:0] rom_addr;
	logic [XW-1:0] deg_x3;

	logic signed [amcp_pkg::SAMPLE_W:0]   dev;
	logic signed [amcp_pkg::RAD_W-1:0]    scaled;
	logic signed [amcp_pkg::RAD_W-1:0]    radius;
	logic signed [amcp_pkg::RAD_W-1:0]    rad_abs;

	logic signed [TW-1:0] cos_s1, sin_s1;

	logic [amcp_pkg::RAD_MAG_W-1:0] rmag_q;
	logic                           rneg_q;
	logic [amcp_pkg::DCNT_W-1:0]    dcnt_q;
	amcp_pkg::sector_t              sector_q, sector_d;
	logic signed [AW-1:0]           acc_x_q, acc_y_q;

	logic [amcp_pkg::DIGIT_W-1:0] digit;
	logic signed [MW-1:0]         term_x, term_y;

	logic             accept, out_free, load_out, ready;
	logic             pvalid_q;
	amcp_pkg::point_t point_q;

	function automatic logic [amcp_pkg::COORD_W-1:0] place(
		input logic signed [AW-1:0]              acc,
		input logic                              neg,
		input logic [amcp_pkg::CENTER_W-1:0]     ctr
	);
		logic signed [AW-1:0]              prod;
		logic signed [AW-1:0]              sum;
		logic [WW-1:0]                     whole;
		logic [amcp_pkg::COORD_W-1:0]      res;
		prod  = neg ? -acc : acc;
		sum   = prod + $signed(AW'({ctr, TRIG_FRAC_BITS'(0)}));
		whole = sum[AW-1:TRIG_FRAC_BITS];
		if (sum[AW-1]) begin
			res = '0;
		end else if (whole > WW'(amcp_pkg::COORD_MAX)) begin
			res = amcp_pkg::COORD_W'(amcp_pkg::COORD_MAX);
		end else begin
			res = whole[amcp_pkg::COORD_W-1:0];
		end
		return res;
	endfunction

	amcp_trig_rom #(
		.ANGLE_STEPS    (ANGLE_STEPS),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_trig_rom (
		.clk    (clk),
		.addr   (rom_addr),
		.cos_s1 (cos_s1),
		.sin_s1 (sin_s1)
	);

	assign out_free = !pvalid_q || point.ready;
	assign ready    = (state_q == amcp_pkg::ST_IDLE)
		|| ((state_q == amcp_pkg::ST_FIN) && out_free);
	assign accept   = sample.valid && ready;
	assign load_out = (state_q == amcp_pkg::ST_FIN) && out_free;

	assign sample.ready  = ready;
	assign point.valid   = pvalid_q;
	assign point.payload = point_q;

	// advance phase, wrap at the end of the turn
	assign deg_next = (degree_q >= DW'(ANGLE_STEPS - 1)) ? '0 : degree_q + DW'(1);
	// hold the table on the current phase while the multiply runs
	assign rom_addr = accept ? deg_next : degree_q;
	assign deg_x3   = XW'(deg_next) + XW'({deg_next, 1'b0});

	always_comb begin
		if (deg_x3 < XW'(ANGLE_STEPS)) begin
			sector_d = amcp_pkg::SEC_RED;
		end else if (deg_x3 < XW'(2 * ANGLE_STEPS)) begin
			sector_d = amcp_pkg::SEC_GREEN;
		end else begin
			sector_d = amcp_pkg::SEC_BLUE;
		end
	end

	assign dev     = $signed({1'b0, sample.payload.audio_sample})
		- $signed((amcp_pkg::SAMPLE_W + 1)'(amcp_pkg::SAMPLE_MID));
	assign scaled  = dev * $signed({1'b0, gain_q});
	assign radius  = $signed(amcp_pkg::RAD_W'(base_q)) + scaled;
	assign rad_abs = radius[amcp_pkg::RAD_W-1] ? -radius : radius;

	assign digit  = rmag_q[amcp_pkg::RAD_MAG_W-1 -: amcp_pkg::DIGIT_W];
	assign term_x = cos_s1 * $signed({1'b0, digit});
	assign term_y = sin_s1 * $signed({1'b0, digit});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			amcp_pkg::ST_IDLE: begin
				if (accept) state_d = amcp_pkg::ST_MUL;
			end
			amcp_pkg::ST_MUL: begin
				if (dcnt_q == '0) state_d = amcp_pkg::ST_FIN;
			end
			amcp_pkg::ST_FIN: begin
				if (out_free) state_d = accept ? amcp_pkg::ST_MUL : amcp_pkg::ST_IDLE;
			end
			default: state_d = amcp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amcp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= amcp_pkg::BASE_RESET;
			gain_q   <= amcp_pkg::GAIN_RESET;
			center_q <= amcp_pkg::CENTER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				amcp_pkg::REG_BASE_RADIUS:   base_q   <= cfg_data[amcp_pkg::BASE_W-1:0];
				amcp_pkg::REG_AUDIO_GAIN:    gain_q   <= cfg_data[amcp_pkg::GAIN_W-1:0];
				amcp_pkg::REG_CENTER_OFFSET: center_q <= cfg_data[amcp_pkg::CENTER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			pvalid_q <= 1'b0;
		end else begin
			if (accept) degree_q <= deg_next;
			if (load_out) begin
				pvalid_q <= 1'b1;
			end else if (point.ready) begin
				pvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rmag_q   <= rad_abs[amcp_pkg::RAD_MAG_W-1:0];
			rneg_q   <= radius[amcp_pkg::RAD_W-1];
			dcnt_q   <= amcp_pkg::DCNT_W'(amcp_pkg::DIGITS - 1);
			sector_q <= sector_d;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
		end else if (state_q == amcp_pkg::ST_MUL) begin
			rmag_q  <= rmag_q << amcp_pkg::DIGIT_W;
			dcnt_q  <= dcnt_q - amcp_pkg::DCNT_W'(1);
			acc_x_q <= (acc_x_q <<< amcp_pkg::DIGIT_W) + AW'(term_x);
			acc_y_q <= (acc_y_q <<< amcp_pkg::DIGIT_W) + AW'(term_y);
		end
		if (load_out) begin
			point_q.point_x     <= place(acc_x_q, rneg_q, center_q);
			point_q.point_y     <= place(acc_y_q, rneg_q, center_q);
			point_q.red_level   <= (sector_q == amcp_pkg::SEC_RED)
				? amcp_pkg::LEVEL_ON : amcp_pkg::LEVEL_OFF;
			point_q.green_level <= (sector_q == amcp_pkg::SEC_GREEN)
				? amcp_pkg::LEVEL_ON : amcp_pkg::LEVEL_OFF;
			point_q.blue_level  <= (sector_q == amcp_pkg::SEC_BLUE)
				? amcp_pkg::LEVEL_ON : amcp_pkg::LEVEL_OFF;
		end
	end

endmodule

// ===== hw/rtl/amcp_checker.sv =====
// Port-level checks of the audio circle point generator, bound to the top.
// Depends on amcp_pkg and audio_modulated_circle_points_top_defines.svh.
`include "audio_modulated_circle_points_top_defines.svh"

module amcp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input amcp_pkg::point_t out_payload
);
	logic       in_take;
	logic       out_stall;
	logic [2:0] lit_on;
	logic       colour_ok;

	assign in_take   = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;
	assign lit_on    = {out_payload.red_level == amcp_pkg::LEVEL_ON,
		out_payload.green_level == amcp_pkg::LEVEL_ON,
		out_payload.blue_level == amcp_pkg::LEVEL_ON};
	assign colour_ok = $onehot(lit_on) && ($countones({out_payload.red_level,
		out_payload.green_level, out_payload.blue_level}) == 8);

	`AMCP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload), "point not held")
	`AMCP_ASSERT_SAME(a_one_colour, out_valid, colour_ok, "colour not a single full channel")
	`AMCP_ASSERT_SAME(a_latency, $rose(out_valid), $past(in_take, 5), "point latency wrong")
	`AMCP_ASSERT_NEXT(a_spacing, in_take, !in_take ##1 !in_take ##1 !in_take, "requests too close")

endmodule

bind audio_modulated_circle_points_top amcp_checker u_amcp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.out_valid   (point.valid),
	.out_ready   (point.ready),
	.out_payload (point.payload)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for audio_modulated_circle_points_top: drives audio requests and
// register writes, predicts each circle point and checks every field of every point.
// Depends on amcp_pkg, amcp_stream_if and the RTL of the block.
module testbench;
	import amcp_pkg::*;

	localparam int ANGLE_STEPS    = 360;
	localparam int TRIG_FRAC_BITS = 14;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1 << 30;
	localparam int SETTLE_CYCLES  = 8;
	localparam int STALL_LIMIT    = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	amcp_stream_if #(.T(sample_t)) sample_ch ();
	amcp_stream_if #(.T(point_t))  point_ch ();

	audio_modulated_circle_points_top #(
		.ANGLE_STEPS    (ANGLE_STEPS),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.point     (point_ch)
	);

	int cos_tab [ANGLE_STEPS];
	int sin_tab [ANGLE_STEPS];
	logic [8:0] phase_step;
	logic [BASE_W-1:0] model_base;
	logic [GAIN_W-1:0] model_gain;
	logic [CENTER_W-1:0] model_center;
	point_t expected_points [$];
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;
	bit quiet = 1'b0;
	int ready_left = 0;
	bit ready_stall = 1'b1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned taylor_q30(longint unsigned a, bit want_cos);
		longint unsigned a2;
		longint unsigned term;
		longint unsigned div;
		longint sum;
		a2 = (a * a) >> 30;
		term = want_cos ? ONE_Q30 : a;
		sum = longint'(term);
		for (int n = 1; n <= 9; n++) begin
			div = want_cos ? (2 * n - 1) * (2 * n) : (2 * n) * (2 * n + 1);
			term = ((term * a2) >> 30) / div;
			if (n % 2)
				sum -= longint'(term);
			else
				sum += longint'(term);
		end
		if (sum < 0)
			sum = 0;
		return sum;
	endfunction

	function automatic int trig_entry(int k, bit want_cos);
		longint unsigned four;
		longint unsigned quad;
		longint unsigned rem;
		longint unsigned angle;
		longint unsigned mag;
		bit use_cos;
		bit neg;
		four = 4 * k;
		quad = (four / ANGLE_STEPS) & 3;
		rem = four % ANGLE_STEPS;
		angle = (HALF_PI_Q30 * rem) / ANGLE_STEPS;
		if (want_cos) begin
			use_cos = (quad == 0 || quad == 2);
			neg = (quad == 1 || quad == 2);
		end else begin
			use_cos = (quad == 1 || quad == 3);
			neg = (quad >= 2);
		end
		mag = taylor_q30(angle, use_cos);
		mag = (mag + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
		return neg ? -int'(mag) : int'(mag);
	endfunction

	function automatic logic [COORD_W-1:0] place_coord(int trig, int radius);
		longint total;
		longint whole;
		total = longint'(trig) * longint'(radius) + (longint'(model_center) << TRIG_FRAC_BITS);
		if (total < 0)
			return '0;
		whole = total >>> TRIG_FRAC_BITS;
		return (whole > COORD_MAX) ? COORD_W'(COORD_MAX) : COORD_W'(whole);
	endfunction

	task automatic predict_point(input logic [SAMPLE_W-1:0] audio);
		point_t want;
		int radius;
		int k;
		if (phase_step >= ANGLE_STEPS - 1)
			phase_step = '0;
		else
			phase_step = phase_step + 1'b1;
		k = phase_step;
		radius = int'(model_base) + (int'(audio) - SAMPLE_MID) * int'(model_gain);
		want.point_x = place_coord(cos_tab[k], radius);
		want.point_y = place_coord(sin_tab[k], radius);
		want.red_level = LEVEL_OFF;
		want.green_level = LEVEL_OFF;
		want.blue_level = LEVEL_OFF;
		if (3 * k < ANGLE_STEPS)
			want.red_level = LEVEL_ON;
		else if (3 * k < 2 * ANGLE_STEPS)
			want.green_level = LEVEL_ON;
		else
			want.blue_level = LEVEL_ON;
		expected_points.push_back(want);
	endtask

	// valid stays high from one request to the next unless a gap is inserted
	task automatic send_sample(input logic [SAMPLE_W-1:0] audio);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.payload.audio_sample <= audio;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		predict_point(audio);
	endtask

	task automatic drain;
		sample_ch.valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_BASE_RADIUS:   model_base = data[BASE_W-1:0];
			REG_AUDIO_GAIN:    model_gain = data[GAIN_W-1:0];
			REG_CENTER_OFFSET: model_center = data[CENTER_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] base_w, gain_w, center_w);
		write_reg(REG_BASE_RADIUS, base_w);
		write_reg(REG_AUDIO_GAIN, gain_w);
		write_reg(REG_CENTER_OFFSET, center_w);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_reg_value(int width);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return CFG_DATA_W'((1 << width) - 1);
			2: return '1;
			default: return CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample;
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return SAMPLE_W'(SAMPLE_MID);
			default: return SAMPLE_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic test_reset_defaults;
		send_sample(8'd128);
		send_sample(8'd0);
		send_sample(8'd255);
		send_sample(8'h55);
		send_sample(8'hAA);
		drain();
	endtask

	task automatic test_register_extremes;
		// widest circle at the top corner, bits above each register dropped
		program_regs('1, '1, '1);
		send_sample(8'd255);
		send_sample(8'd0);
		drain();
		// most negative radius around the origin
		program_regs('0, '1, '0);
		send_sample(8'd0);
		send_sample(8'd255);
		send_sample(8'd128);
		drain();
		program_regs(12'd1023, '0, 12'd2048);
		send_sample(8'd77);
		drain();
		program_regs('0, '0, '0);
		send_sample(8'd200);
		drain();
	endtask

	task automatic test_spare_index;
		program_regs(12'd300, 12'd7, 12'd1000);
		write_reg(REG_SPARE, '1);
		send_sample(8'd10);
		send_sample(8'd250);
		drain();
	endtask

	task automatic test_random_settings;
		for (int p = 0; p < 6; p++) begin
			program_regs(pick_reg_value(BASE_W), pick_reg_value(GAIN_W),
				pick_reg_value(CENTER_W));
			repeat (250) send_sample(pick_sample());
			drain();
		end
	endtask

	task automatic test_back_to_back;
		quiet = 1'b1;
		program_regs(pick_reg_value(BASE_W), pick_reg_value(GAIN_W), pick_reg_value(CENTER_W));
		repeat (350) send_sample(pick_sample());
		drain();
	endtask

	always @(posedge clk) begin
		if (quiet) begin
			point_ch.ready <= 1'b1;
		end else begin
			if (ready_left == 0) begin
				ready_stall = !ready_stall;
				ready_left = ready_stall ? $urandom_range(1, 10) : $urandom_range(1, 40);
			end
			ready_left--;
			point_ch.ready <= !ready_stall;
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		point_t want;
		point_t got;
		if (arst_n && point_ch.valid && point_ch.ready) begin
			got = point_ch.payload;
			if (expected_points.size() == 0) begin
				$error("point with no request outstanding: x %0d y %0d", got.point_x,
					got.point_y);
				error_count++;
			end else begin
				want = expected_points.pop_front();
				check_field("point_x", want.point_x, got.point_x);
				check_field("point_y", want.point_y, got.point_y);
				check_field("red_level", want.red_level, got.red_level);
				check_field("green_level", want.green_level, got.green_level);
				check_field("blue_level", want.blue_level, got.blue_level);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (point_ch.valid && point_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.payload = '0;
		point_ch.ready = 1'b0;
		phase_step = '0;
		model_base = BASE_RESET;
		model_gain = GAIN_RESET;
		model_center = CENTER_RESET;
		for (int k = 0; k < ANGLE_STEPS; k++) begin
			cos_tab[k] = trig_entry(k, 1'b1);
			sin_tab[k] = trig_entry(k, 1'b0);
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_spare_index();
		test_random_settings();
		test_back_to_back();

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/amcp_pkg.sv
hw/rtl/amcp_stream_if.sv
hw/rtl/amcp_trig_rom.sv
hw/rtl/audio_modulated_circle_points_top.sv
hw/rtl/amcp_checker.sv
tb/sv/testbench.sv
